// File: hw/rtl/cgm_pkg.sv
// package: shared types, constants and distance function for the gradient magnitude core
package cgm_pkg;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;

  localparam int CFG_DATA_W   = 11;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_RST_SIZE = 1024;
  localparam int MIN_SIZE     = 2;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_FLUSH = 1'b1;

  localparam int          CHAN_W  = 8;
  localparam int          PIX_W   = 3 * CHAN_W;
  localparam logic [7:0]  MAG_MAX = 8'd255;

  typedef logic [CHAN_W-1:0] chan_t;

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
  } pixel_t;

  typedef struct packed {
    logic [7:0] magnitude;
    logic       frame_end;
  } result_t;

  function automatic chan_t abs_diff(chan_t a, chan_t b);
    abs_diff = (a > b) ? (a - b) : (b - a);
  endfunction

  // largest per-channel absolute difference
  function automatic chan_t color_dist(pixel_t a, pixel_t b);
    chan_t db;
    chan_t dg;
    chan_t dr;
    chan_t m;
    db = abs_diff(a.blue, b.blue);
    dg = abs_diff(a.green, b.green);
    dr = abs_diff(a.red, b.red);
    m  = (dg > db) ? dg : db;
    color_dist = (dr > m) ? dr : m;
  endfunction

endpackage

// File: hw/rtl/color_gradient_magnitude_core.sv
// top level: streaming color gradient magnitude with two line stores
// throughput: one item per cycle while in_stall is low; line store reads are issued
// from the next column value so the following item's data is ready at the next edge
// a result enters the queue at the accepting edge, out_valid is set from the
// queue count; results for row r come while row r+1 (or flush items) is taken
// reset: counters, drain flag and output queue cleared; line stores are not cleared
module color_gradient_magnitude_core #(
  parameter int MAX_WIDTH  = cgm_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = cgm_pkg::DEF_MAX_HEIGHT
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // configuration
  input  logic                             cfg_we,
  input  logic [cgm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [cgm_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  // input items
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_req_type,
  input  logic [7:0]                       in_blue,
  input  logic [7:0]                       in_green,
  input  logic [7:0]                       in_red,
  // result items
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [7:0]                       out_magnitude,
  output logic                             out_frame_end
);

  localparam int AW  = $clog2(MAX_WIDTH);       // column index
  localparam int WW  = $clog2(MAX_WIDTH + 1);   // frame width value
  localparam int RW  = $clog2(MAX_HEIGHT);      // row index
  localparam int HW  = $clog2(MAX_HEIGHT + 1);  // frame height value
  localparam int RST_W = (MAX_WIDTH  < cgm_pkg::CFG_RST_SIZE) ? MAX_WIDTH
                                                               : cgm_pkg::CFG_RST_SIZE;
  localparam int RST_H = (MAX_HEIGHT < cgm_pkg::CFG_RST_SIZE) ? MAX_HEIGHT
                                                               : cgm_pkg::CFG_RST_SIZE;

  // frame geometry
  logic [WW-1:0] width_r, width_nxt;
  logic [HW-1:0] height_r, height_nxt;

  // scan position
  logic [AW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic          drain_r, drain_nxt;
  cgm_pkg::pixel_t left_r, left_nxt;   // newer row pixel left of the current column

  // two-entry output queue so input keeps flowing while a result waits
  cgm_pkg::result_t slot0_r, slot0_nxt, slot1_r, slot1_nxt;
  logic [1:0]       cnt_r, cnt_nxt;

  logic in_acc, is_flush, last_col, last_row, first_col;
  logic wr_en, res_vld, pop;
  cgm_pkg::result_t res;

  cgm_pkg::pixel_t px, newer0, newer1, older0;
  logic [8:0]  grad_x, grad_y;
  logic [9:0]  grad_sum;

  assign px        = '{red: in_red, green: in_green, blue: in_blue};
  assign in_stall  = (cnt_r == 2'd2);
  assign in_acc    = in_valid && !in_stall;
  assign is_flush  = (in_req_type == cgm_pkg::REQ_FLUSH);
  assign first_col = (col_r == '0);
  assign last_col  = (WW'(col_r) == width_r - WW'(1));
  assign last_row  = (HW'(row_r) == height_r - HW'(1));

  // reads for the item after this edge: its column and the one to its right
  cgm_line_buf #(
    .DEPTH (MAX_WIDTH),
    .AW    (AW)
  ) u_line_buf (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_addr  (col_r),
    .wr_pixel (px),
    .rd_addr0 (col_nxt),
    .rd_addr1 (col_nxt + AW'(1)),
    .newer0   (newer0),
    .newer1   (newer1),
    .older0   (older0)
  );

  // horizontal term: one-sided and doubled on the border columns
  always_comb begin
    if (first_col) begin
      grad_x = {cgm_pkg::color_dist(newer1, newer0), 1'b0};
    end else if (last_col) begin
      grad_x = {cgm_pkg::color_dist(newer0, left_r), 1'b0};
    end else begin
      grad_x = {1'b0, cgm_pkg::color_dist(left_r, newer1)};
    end
  end

  // vertical term: flush means bottom row, row one means top row of the frame
  always_comb begin
    if (is_flush) begin
      grad_y = {cgm_pkg::color_dist(newer0, older0), 1'b0};
    end else if (row_r == RW'(1)) begin
      grad_y = {cgm_pkg::color_dist(px, newer0), 1'b0};
    end else begin
      grad_y = {1'b0, cgm_pkg::color_dist(older0, px)};
    end
  end

  assign grad_sum      = {1'b0, grad_x} + {1'b0, grad_y};

  // scan control and configuration
  always_comb begin
    width_nxt     = width_r;
    height_nxt    = height_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    drain_nxt     = drain_r;
    left_nxt      = left_r;
    wr_en         = 1'b0;
    res_vld       = 1'b0;
    res.magnitude = (grad_sum > 10'(cgm_pkg::MAG_MAX)) ? cgm_pkg::MAG_MAX : grad_sum[7:0];
    res.frame_end = 1'b0;
    if (cfg_we) begin
      // any register write restarts the frame
      col_nxt   = '0;
      row_nxt   = '0;
      drain_nxt = 1'b0;
      left_nxt  = '0;
      unique case (cfg_index)
        cgm_pkg::REG_FRAME_WIDTH: begin
          if (int'(cfg_wdata) < cgm_pkg::MIN_SIZE) begin
            width_nxt = WW'(cgm_pkg::MIN_SIZE);
          end else if (int'(cfg_wdata) > MAX_WIDTH) begin
            width_nxt = WW'(MAX_WIDTH);
          end else begin
            width_nxt = WW'(cfg_wdata);
          end
        end
        cgm_pkg::REG_FRAME_HEIGHT: begin
          if (int'(cfg_wdata) < cgm_pkg::MIN_SIZE) begin
            height_nxt = HW'(cgm_pkg::MIN_SIZE);
          end else if (int'(cfg_wdata) > MAX_HEIGHT) begin
            height_nxt = HW'(MAX_HEIGHT);
          end else begin
            height_nxt = HW'(cfg_wdata);
          end
        end
        default: begin
          width_nxt = width_r;
        end
      endcase
    end else if (in_acc) begin
      if (is_flush && drain_r) begin
        // drain the last row out of the newer store
        res_vld  = 1'b1;
        left_nxt = newer0;
        if (last_col) begin
          res.frame_end = 1'b1;
          col_nxt       = '0;
          row_nxt       = '0;
          drain_nxt     = 1'b0;
          left_nxt      = '0;
        end else begin
          col_nxt = col_r + AW'(1);
        end
      end else if (!is_flush && !drain_r) begin
        wr_en    = 1'b1;
        res_vld  = (row_r != '0);
        left_nxt = newer0;
        if (last_col) begin
          col_nxt  = '0;
          left_nxt = '0;
          if (last_row) begin
            row_nxt   = '0;
            drain_nxt = 1'b1;
          end else begin
            row_nxt = row_r + RW'(1);
          end
        end else begin
          col_nxt = col_r + AW'(1);
        end
      end
      // early flush and pixels during drain are dropped
    end
  end

  // output queue
  assign pop           = (cnt_r != 2'd0) && !out_stall;
  assign out_valid     = (cnt_r != 2'd0);
  assign out_magnitude = slot0_r.magnitude;
  assign out_frame_end = slot0_r.frame_end;

  always_comb begin
    slot0_nxt = slot0_r;
    slot1_nxt = slot1_r;
    cnt_nxt   = cnt_r;
    if (res_vld && pop) begin
      if (cnt_r == 2'd1) begin
        slot0_nxt = res;
      end else begin
        slot0_nxt = slot1_r;
        slot1_nxt = res;
      end
    end else if (res_vld) begin
      if (cnt_r == 2'd0) begin
        slot0_nxt = res;
      end else begin
        slot1_nxt = res;
      end
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop) begin
      slot0_nxt = slot1_r;
      cnt_nxt   = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WW'(RST_W);
      height_r <= HW'(RST_H);
      col_r    <= '0;
      row_r    <= '0;
      drain_r  <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      drain_r  <= drain_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    left_r  <= left_nxt;
    slot0_r <= slot0_nxt;
    slot1_r <= slot1_nxt;
  end

endmodule

// File: hw/rtl/cgm_line_buf.sv
// two line stores with registered reads and write-to-read forwarding
module cgm_line_buf #(
  parameter int DEPTH = cgm_pkg::DEF_MAX_WIDTH,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  cgm_pkg::pixel_t  wr_pixel,
  input  logic [AW-1:0]    rd_addr0,
  input  logic [AW-1:0]    rd_addr1,
  output cgm_pkg::pixel_t  newer0,
  output cgm_pkg::pixel_t  newer1,
  output cgm_pkg::pixel_t  older0
);

  cgm_pkg::pixel_t newer_mem [DEPTH];
  cgm_pkg::pixel_t older_mem [DEPTH];

  cgm_pkg::pixel_t new0_q_r, new1_q_r, old0_q_r;
  cgm_pkg::pixel_t wr_pixel_r, wr_older_r;
  logic            fwd0_r, fwd1_r;

  // older store takes what newer held at the written column
  always_ff @(posedge clk) begin
    if (wr_en) begin
      newer_mem[wr_addr] <= wr_pixel;
      older_mem[wr_addr] <= newer0;
    end
  end

  always_ff @(posedge clk) begin
    new0_q_r   <= newer_mem[rd_addr0];
    new1_q_r   <= newer_mem[rd_addr1];
    old0_q_r   <= older_mem[rd_addr0];
    fwd0_r     <= wr_en && (wr_addr == rd_addr0);
    fwd1_r     <= wr_en && (wr_addr == rd_addr1);
    wr_pixel_r <= wr_pixel;
    wr_older_r <= newer0;
  end

  assign newer0 = fwd0_r ? wr_pixel_r : new0_q_r;
  assign newer1 = fwd1_r ? wr_pixel_r : new1_q_r;
  assign older0 = fwd0_r ? wr_older_r : old0_q_r;

endmodule

// File: tb/cgm_checker.sv
// checker for the gradient magnitude core: tracks the image, predicts and compares result items
module cgm_checker #(
  parameter int MAX_WIDTH  = cgm_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = cgm_pkg::DEF_MAX_HEIGHT
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [cgm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cgm_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic                           in_req_type,
  input  logic [7:0]                     in_blue,
  input  logic [7:0]                     in_green,
  input  logic [7:0]                     in_red,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic [7:0]                     out_magnitude,
  input  logic                           out_frame_end,
  output int                             fail_count,
  output int                             results_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // mirror of the image held by the block
  cgm_pkg::pixel_t older_line [MAX_WIDTH];
  cgm_pkg::pixel_t newer_line [MAX_WIDTH];
  cgm_pkg::pixel_t left_above;
  int unsigned     col_pos;
  int unsigned     row_pos;
  int unsigned     line_len;
  int unsigned     line_count;
  bit              in_drain;

  cgm_pkg::result_t gradient_queue [$];

  function automatic int unsigned chan_gap(cgm_pkg::chan_t a, cgm_pkg::chan_t b);
    int d;
    d = int'(a) - int'(b);
    return (d < 0) ? -d : d;
  endfunction

  // color distance: worst channel
  function automatic int unsigned pixel_gap(cgm_pkg::pixel_t a, cgm_pkg::pixel_t b);
    int unsigned g;
    g = chan_gap(a.blue, b.blue);
    if (chan_gap(a.green, b.green) > g) g = chan_gap(a.green, b.green);
    if (chan_gap(a.red, b.red) > g) g = chan_gap(a.red, b.red);
    return g;
  endfunction

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
    if (v < cgm_pkg::MIN_SIZE) return cgm_pkg::MIN_SIZE;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic [7:0] saturate(int unsigned s);
    return (s > 255) ? cgm_pkg::MAG_MAX : s[7:0];
  endfunction

  // horizontal gradient over the row in newer_line
  function automatic int unsigned horiz_grad(int unsigned c);
    if (c == 0) return 2 * pixel_gap(newer_line[1], newer_line[0]);
    if (c >= line_len - 1) return 2 * pixel_gap(newer_line[line_len - 1], left_above);
    return pixel_gap(left_above, newer_line[c + 1]);
  endfunction

  function automatic void restart_frame();
    col_pos    = 0;
    row_pos    = 0;
    in_drain   = 1'b0;
    left_above = '0;
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t cgm_checker: %s", $realtime, what);
    fail_count++;
  endtask

  task automatic predict_item(input logic kind, input cgm_pkg::pixel_t px);
    int unsigned      c;
    int unsigned      vert;
    cgm_pkg::result_t r;
    c = (col_pos >= line_len) ? line_len - 1 : col_pos;
    if (kind == cgm_pkg::REQ_FLUSH) begin
      if (!in_drain) return;
      r.magnitude = saturate(horiz_grad(c) + 2 * pixel_gap(newer_line[c], older_line[c]));
      r.frame_end = (c + 1 >= line_len);
      gradient_queue = {gradient_queue, r};
      left_above = newer_line[c];
      if (r.frame_end) restart_frame();
      else col_pos = c + 1;
      return;
    end
    if (in_drain) return;
    if (row_pos >= 1) begin
      vert = (row_pos == 1) ? 2 * pixel_gap(px, newer_line[c]) : pixel_gap(older_line[c], px);
      r.magnitude = saturate(horiz_grad(c) + vert);
      r.frame_end = 1'b0;
      gradient_queue = {gradient_queue, r};
    end
    left_above    = newer_line[c];
    older_line[c] = newer_line[c];
    newer_line[c] = px;
    if (c + 1 >= line_len) begin
      col_pos    = 0;
      left_above = '0;
      if (row_pos + 1 >= line_count) begin
        row_pos  = 0;
        in_drain = 1'b1;
      end else begin
        row_pos++;
      end
    end else begin
      col_pos = c + 1;
    end
  endtask

  task automatic check_result();
    cgm_pkg::result_t want;
    if (gradient_queue.size() == 0) begin
      report_mismatch($sformatf("unexpected result item: magnitude %0d frame_end %0b",
                                out_magnitude, out_frame_end));
      return;
    end
    want = gradient_queue.pop_front();
    if (out_magnitude !== want.magnitude)
      report_mismatch($sformatf("magnitude got %0d want %0d", out_magnitude, want.magnitude));
    if (out_frame_end !== want.frame_end)
      report_mismatch($sformatf("frame_end got %0b want %0b", out_frame_end, want.frame_end));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      line_len   = clamp_dim(cgm_pkg::CFG_RST_SIZE, MAX_WIDTH);
      line_count = clamp_dim(cgm_pkg::CFG_RST_SIZE, MAX_HEIGHT);
      restart_frame();
      gradient_queue.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == cgm_pkg::REG_FRAME_WIDTH) begin
          line_len = clamp_dim(cfg_wdata, MAX_WIDTH);
        end else if (cfg_index == cgm_pkg::REG_FRAME_HEIGHT) begin
          line_count = clamp_dim(cfg_wdata, MAX_HEIGHT);
        end
        restart_frame();
      end
      if (in_valid && !in_stall) predict_item(in_req_type, {in_red, in_green, in_blue});
      if (out_valid && !out_stall) check_result();
    end
    results_pending = gradient_queue.size();
  end

endmodule

// File: tb/tb_top.sv
// testbench top: clock, reset, stimulus and verdict for the gradient magnitude core
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS   = 700;
  localparam int WIDE_CUT       = 1040;  // first row plus a few pixels of the second
  localparam int TALL_CUT       = 48;
  localparam int SETTLE_CYCLES  = 4;     // result enters the output queue at the accepting edge
  localparam int DRAIN_CYCLES   = 20;
  localparam int WATCHDOG_LIMIT = 3000;  // well above the longest input gap or output stall run

  typedef enum int unsigned {
    STYLE_NOISE,
    STYLE_SMOOTH,
    STYLE_BINARY,
    STYLE_FLAT
  } image_style_t;

  logic                           clk;
  logic                           rst_n;
  logic                           cfg_we;
  logic [cgm_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [cgm_pkg::CFG_DATA_W-1:0] cfg_wdata;
  logic                           in_valid;
  logic                           in_stall;
  logic                           in_req_type;
  logic [7:0]                     in_blue;
  logic [7:0]                     in_green;
  logic [7:0]                     in_red;
  logic                           out_valid;
  logic                           out_stall;
  logic [7:0]                     out_magnitude;
  logic                           out_frame_end;

  int                             fail_count;
  int                             results_pending;

  // when set the sender streams back to back
  bit                             no_gap_mode;

  color_gradient_magnitude_core dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_req_type   (in_req_type),
    .in_blue       (in_blue),
    .in_green      (in_green),
    .in_red        (in_red),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_magnitude (out_magnitude),
    .out_frame_end (out_frame_end)
  );

  cgm_checker grad_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_req_type     (in_req_type),
    .in_blue         (in_blue),
    .in_green        (in_green),
    .in_red          (in_red),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_magnitude   (out_magnitude),
    .out_frame_end   (out_frame_end),
    .fail_count      (fail_count),
    .results_pending (results_pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic int unsigned dim_of(int unsigned v, int unsigned hi);
    if (v < cgm_pkg::MIN_SIZE) return cgm_pkg::MIN_SIZE;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic cgm_pkg::pixel_t random_pixel();
    return cgm_pkg::pixel_t'(24'($urandom));
  endfunction

  function automatic cgm_pkg::pixel_t make_pixel(image_style_t style, cgm_pkg::pixel_t base);
    cgm_pkg::pixel_t p;
    case (style)
      STYLE_SMOOTH: begin
        // small local variation keeps sums below saturation
        p = base ^ cgm_pkg::pixel_t'(24'($urandom & 32'h000f0f0f));
      end
      STYLE_BINARY: begin
        p.blue  = $urandom_range(0, 1) ? 8'hff : 8'h00;
        p.green = $urandom_range(0, 1) ? 8'hff : 8'h00;
        p.red   = $urandom_range(0, 1) ? 8'hff : 8'h00;
      end
      STYLE_FLAT: begin
        p = base;
      end
      default: begin
        p = random_pixel();
      end
    endcase
    return p;
  endfunction

  // result side back-pressure: ready stretches, some long, then stall runs
  initial begin : result_backpressure
    int unsigned n;
    out_stall = 1'b0;
    forever begin
      n = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 400) : $urandom_range(0, 12);
      repeat (n) @(negedge clk) out_stall <= 1'b0;
      n = pick_gap();
      repeat (n) @(negedge clk) out_stall <= 1'b1;
    end
  end

  // ends the run when no item moves on either channel for too long
  initial begin : watchdog
    int unsigned idle;
    idle = 0;
    while (idle < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle = 0;
      else idle++;
    end
    $display("tb: failure");
    $finish;
  end

  // one item, held until the block takes it
  task automatic send_item(input logic kind, input cgm_pkg::pixel_t px);
    int unsigned gap;
    gap = no_gap_mode ? 0 : pick_gap();
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid    <= 1'b1;
    in_req_type <= kind;
    in_blue     <= px.blue;
    in_green    <= px.green;
    in_red      <= px.red;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // sender goes quiet until every predicted result has come out
  task automatic wait_results_done();
    @(negedge clk);
    in_valid <= 1'b0;
    while (results_pending != 0) @(negedge clk);
  endtask

  // register writes only on an idle block
  task automatic write_reg(input logic [cgm_pkg::CFG_IDX_W-1:0] idx,
                           input logic [cgm_pkg::CFG_DATA_W-1:0] val);
    wait_results_done();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // raster pixels then the flush items for the last row
  // stop_at cuts the frame short, the next write restarts it
  // noisy mixes in early flushes and pixels during the drain
  task automatic stream_frame(input int unsigned w, input int unsigned h,
                              input image_style_t style, input bit noisy,
                              input int unsigned stop_at, input bit hold_mid);
    cgm_pkg::pixel_t base;
    int unsigned     n;
    base = random_pixel();
    for (n = 0; n < w * h; n++) begin
      if (stop_at != 0 && n == stop_at) return;
      if (hold_mid && n == (w * h) / 2) wait_results_done();
      if (noisy && $urandom_range(0, 19) == 0) send_item(cgm_pkg::REQ_FLUSH, random_pixel());
      send_item(cgm_pkg::REQ_PIXEL, make_pixel(style, base));
    end
    for (n = 0; n < w; n++) begin
      if (noisy && $urandom_range(0, 9) == 0) send_item(cgm_pkg::REQ_PIXEL, random_pixel());
      send_item(cgm_pkg::REQ_FLUSH, random_pixel());
    end
    // flush after the frame end is an early flush of the next frame
    if (noisy && $urandom_range(0, 3) == 0) send_item(cgm_pkg::REQ_FLUSH, random_pixel());
  endtask

  initial begin : stimulus
    int unsigned  w;
    int unsigned  h;
    int unsigned  wv;
    int unsigned  hv;
    int unsigned  counted;
    int unsigned  cut;
    bit           must_write;
    image_style_t style;

    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_index   = cgm_pkg::REG_FRAME_WIDTH;
    cfg_wdata   = '0;
    in_valid    = 1'b0;
    in_req_type = cgm_pkg::REQ_PIXEL;
    in_blue     = '0;
    in_green    = '0;
    in_red      = '0;
    no_gap_mode = 1'b0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // directed 2x2 frame, sizes below the minimum clamp to 2
    write_reg(cgm_pkg::REG_FRAME_WIDTH, 11'd1);
    write_reg(cgm_pkg::REG_FRAME_HEIGHT, 11'd0);
    send_item(cgm_pkg::REQ_FLUSH, random_pixel());        // flush before any pixel
    // pixel literals are red, green, blue
    send_item(cgm_pkg::REQ_PIXEL, cgm_pkg::pixel_t'(24'h000000));
    send_item(cgm_pkg::REQ_PIXEL, cgm_pkg::pixel_t'(24'hffffff));
    send_item(cgm_pkg::REQ_FLUSH, random_pixel());        // flush mid frame
    send_item(cgm_pkg::REQ_PIXEL, cgm_pkg::pixel_t'(24'h8000ff));
    send_item(cgm_pkg::REQ_PIXEL, cgm_pkg::pixel_t'(24'h01ff00));
    send_item(cgm_pkg::REQ_PIXEL, cgm_pkg::pixel_t'(24'hffffff));  // pixel while draining
    send_item(cgm_pkg::REQ_FLUSH, random_pixel());
    send_item(cgm_pkg::REQ_FLUSH, random_pixel());        // carries frame end
    send_item(cgm_pkg::REQ_FLUSH, random_pixel());        // after frame end, ignored

    // 3x3 reaches an inner column and an inner row
    write_reg(cgm_pkg::REG_FRAME_WIDTH, 11'd3);
    write_reg(cgm_pkg::REG_FRAME_HEIGHT, 11'd3);
    stream_frame(3, 3, STYLE_NOISE, 1'b0, 0, 1'b0);

    // widest frame, oversize width clamps to the line store depth
    // cut once the second row has started so the row wrap is checked
    write_reg(cgm_pkg::REG_FRAME_WIDTH, 11'h7ff);
    write_reg(cgm_pkg::REG_FRAME_HEIGHT, 11'd1);
    stream_frame(dim_of(11'h7ff, cgm_pkg::DEF_MAX_WIDTH), 2, STYLE_NOISE, 1'b1,
                 WIDE_CUT, 1'b0);

    // tallest frame at minimum width, first rows only
    write_reg(cgm_pkg::REG_FRAME_WIDTH, 11'd2);
    write_reg(cgm_pkg::REG_FRAME_HEIGHT, 11'h7ff);
    stream_frame(2, dim_of(11'h7ff, cgm_pkg::DEF_MAX_HEIGHT), STYLE_SMOOTH, 1'b1,
                 TALL_CUT, 1'b0);

    // random frames, mostly small, some back to back without a rewrite
    counted    = 0;
    must_write = 1'b1;
    w          = 2;
    h          = 2;
    while (counted < RANDOM_ITEMS) begin
      if (must_write || $urandom_range(0, 3) != 0) begin
        wv = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 64) : $urandom_range(2, 12);
        hv = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 16) : $urandom_range(2, 6);
        write_reg(cgm_pkg::REG_FRAME_WIDTH, wv[cgm_pkg::CFG_DATA_W-1:0]);
        write_reg(cgm_pkg::REG_FRAME_HEIGHT, hv[cgm_pkg::CFG_DATA_W-1:0]);
        w          = dim_of(wv, cgm_pkg::DEF_MAX_WIDTH);
        h          = dim_of(hv, cgm_pkg::DEF_MAX_HEIGHT);
        must_write = 1'b0;
      end
      style       = image_style_t'($urandom_range(0, 3));
      no_gap_mode = ($urandom_range(0, 4) == 0);
      // abandoned frame, restarted by the next write
      cut = (counted != 0 && $urandom_range(0, 11) == 0) ? $urandom_range(1, w * h - 1) : 0;
      stream_frame(w, h, style, $urandom_range(0, 2) == 0, cut,
                   counted == 0 || $urandom_range(0, 15) == 0);
      counted += (cut != 0) ? cut : w * h + w;
      if (cut != 0) must_write = 1'b1;
    end
    no_gap_mode = 1'b0;

    wait_results_done();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0 && results_pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
